// File: rtl/fcsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsu_pkg: shared types and constants of the four-channel sound unit
// Payload structs, operation codes, register offsets and the duty table.
// ----------------------------------------------------------------------------
package fcsu_pkg;

	typedef struct packed {
		logic [1:0] op;
		logic [5:0] reg_index;
		logic [7:0] write_data;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       sample_valid;
		logic [8:0] terminal1_level;
		logic [8:0] terminal2_level;
	} out_item_t;

	// operations
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;
	localparam logic [1:0] OP_CYCLE = 2'd3;

	// register offsets
	localparam logic [5:0] R_NR10 = 6'd0;
	localparam logic [5:0] R_NR11 = 6'd1;
	localparam logic [5:0] R_NR12 = 6'd2;
	localparam logic [5:0] R_NR13 = 6'd3;
	localparam logic [5:0] R_NR14 = 6'd4;
	localparam logic [5:0] R_NR21 = 6'd6;
	localparam logic [5:0] R_NR22 = 6'd7;
	localparam logic [5:0] R_NR23 = 6'd8;
	localparam logic [5:0] R_NR24 = 6'd9;
	localparam logic [5:0] R_NR30 = 6'd10;
	localparam logic [5:0] R_NR31 = 6'd11;
	localparam logic [5:0] R_NR32 = 6'd12;
	localparam logic [5:0] R_NR33 = 6'd13;
	localparam logic [5:0] R_NR34 = 6'd14;
	localparam logic [5:0] R_NR41 = 6'd16;
	localparam logic [5:0] R_NR42 = 6'd17;
	localparam logic [5:0] R_NR43 = 6'd18;
	localparam logic [5:0] R_NR44 = 6'd19;
	localparam logic [5:0] R_NR50 = 6'd20;
	localparam logic [5:0] R_NR51 = 6'd21;
	localparam logic [5:0] R_NR52 = 6'd22;

	localparam int          WAVE_BYTES  = 16;
	localparam logic [22:0] CYCLE_RATE  = 23'd2097152;
	localparam logic [21:0] RATE_RESET  = 22'd44100;

	function automatic logic [7:0] duty_pattern(input logic [1:0] sel);
		logic [7:0] p;
		case (sel)
			2'd0: p = 8'h01;
			2'd1: p = 8'h81;
			2'd2: p = 8'h87;
			default: p = 8'h7E;
		endcase
		return p;
	endfunction

endpackage

// File: rtl/fcsu_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsu_mixer: per-voice levels and the two terminal mixes
// Picks each voice level, sums the selected voices per terminal and scales
// by (volume + 1). Pure combinational logic.
// ----------------------------------------------------------------------------
module fcsu_mixer (
	input  logic [3:0]  voice_on,
	input  logic [7:0]  nr11,
	input  logic [7:0]  nr21,
	input  logic [7:0]  nr32,
	input  logic [7:0]  nr50,
	input  logic [7:0]  nr51,
	input  logic [2:0]  duty_step0,
	input  logic [2:0]  duty_step1,
	input  logic [3:0]  vol0,
	input  logic [3:0]  vol1,
	input  logic [3:0]  vol3,
	input  logic [7:0]  wave_byte,
	input  logic        wave_low,
	input  logic        noise_bit,
	output logic [8:0]  level1,
	output logic [8:0]  level2
);
	logic [3:0] lv [4];
	logic [7:0] d0, d1;
	logic [3:0] nib;
	logic [1:0] wl;
	logic [5:0] s1, s2;
	logic [8:0] p1, p2;

	// voice levels
	always_comb begin
		d0 = fcsu_pkg::duty_pattern(nr11[7:6]);
		d1 = fcsu_pkg::duty_pattern(nr21[7:6]);
		wl = nr32[6:5];
		nib = wave_low ? wave_byte[3:0] : wave_byte[7:4];
		lv[0] = (voice_on[0] && d0[duty_step0]) ? vol0 : 4'd0;
		lv[1] = (voice_on[1] && d1[duty_step1]) ? vol1 : 4'd0;
		lv[2] = 4'd0;
		if (voice_on[2] && wl != 2'd0)
			lv[2] = nib >> (wl - 2'd1);
		lv[3] = (voice_on[3] && !noise_bit) ? vol3 : 4'd0;
	end

	// terminal sums and volume scale
	always_comb begin
		s1 = '0;
		s2 = '0;
		for (int v = 0; v < 4; v++) begin
			if (nr51[v])     s1 = s1 + {2'd0, lv[v]};
			if (nr51[v + 4]) s2 = s2 + {2'd0, lv[v]};
		end
		p1 = {3'd0, s1} * {5'd0, ({1'b0, nr50[2:0]} + 4'd1)};
		p2 = {3'd0, s2} * {5'd0, ({1'b0, nr50[6:4]} + 4'd1)};
		level1 = p1;
		level2 = p2;
	end
endmodule

// File: rtl/four_channel_sound_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_channel_sound_unit: two pulse, one wave and one noise voice
// Register access, frame ticks and machine cycles in; one result per item.
// ----------------------------------------------------------------------------
// Channel   Signals                            Direction
// input     in_valid / in_stall / in_item      into the block
// output    out_valid / out_stall / out_item   out of the block
// config    cfg_we / cfg_wdata                 sample rate register
//
// One item per clock while in_stall is low; each item is done in the cycle it
// is accepted and its result sits in the output register the next cycle.
// Input is stalled only while a full output register is stalled. arst_n clears
// all state but out_item; the sample rate register resets to 44100.
// ----------------------------------------------------------------------------
module four_channel_sound_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  fcsu_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output fcsu_pkg::out_item_t  out_item,
	input  logic                 cfg_we,
	input  logic [21:0]          cfg_wdata
);
	logic [21:0] rate_q;
	logic [7:0]  nr10_q, nr11_q, nr12_q, nr14_q, nr21_q, nr22_q, nr24_q;
	logic [7:0]  nr30_q, nr32_q, nr34_q, nr42_q, nr43_q, nr44_q, nr50_q, nr51_q;
	logic        unit_en_q;
	logic [1:0]  phase_q;
	logic [3:0]  von_q, len_en_q;
	logic [8:0]  len_q [4];
	logic [2:0]  env_act_q;
	logic [3:0]  env_vol_q [3];
	logic [2:0]  env_cnt_q [3];
	logic [10:0] freq_q [3];
	logic [12:0] timer_q [3];
	logic [2:0]  duty_q [2];
	logic [4:0]  wstep_q;
	logic        sw_act_q;
	logic [10:0] sw_shadow_q;
	logic [2:0]  sw_cnt_q;
	logic [19:0] ntimer_q;
	logic [14:0] nshift_q;
	logic [7:0]  wave_q [16];
	logic [21:0] rphase_q;

	// next-state copies
	logic [3:0]  von_d, len_en_d;
	logic [8:0]  len_d [4];
	logic [2:0]  env_act_d;
	logic [3:0]  env_vol_d [3];
	logic [2:0]  env_cnt_d [3];
	logic [10:0] freq_d [3];
	logic [12:0] timer_d [3];
	logic [2:0]  duty_d [2];
	logic [4:0]  wstep_d;
	logic        sw_act_d;
	logic [10:0] sw_shadow_d;
	logic [2:0]  sw_cnt_d;
	logic [19:0] ntimer_d;
	logic [14:0] nshift_d;
	logic [1:0]  phase_d;
	logic [21:0] rphase_d;
	logic        emit;
	logic [7:0]  rdata;
	logic [8:0]  lvl1, lvl2;

	logic accept;
	fcsu_pkg::out_item_t res;

	assign in_stall = out_valid && out_stall;
	assign accept = in_valid && !in_stall;

	logic [1:0] op;
	logic [5:0] idx;
	logic [7:0] d;
	assign op  = in_item.op;
	assign idx = in_item.reg_index;
	assign d   = in_item.write_data;

	// envelope control bytes per slot
	logic [7:0] env_ctl [3];
	assign env_ctl[0] = nr12_q;
	assign env_ctl[1] = nr22_q;
	assign env_ctl[2] = nr42_q;

	// main next-state logic
	always_comb begin
		logic [2:0]  per, sh;
		logic [10:0] delta;
		logic [11:0] nf;
		logic [22:0] sum;
		logic [3:0]  clks;
		logic [19:0] nbase;
		logic        x;
		logic [10:0] f;
		von_d = von_q; len_en_d = len_en_q; len_d = len_q;
		env_act_d = env_act_q; env_vol_d = env_vol_q; env_cnt_d = env_cnt_q;
		freq_d = freq_q; timer_d = timer_q; duty_d = duty_q; wstep_d = wstep_q;
		sw_act_d = sw_act_q; sw_shadow_d = sw_shadow_q; sw_cnt_d = sw_cnt_q;
		ntimer_d = ntimer_q; nshift_d = nshift_q; phase_d = phase_q;
		rphase_d = rphase_q; emit = 1'b0;
		per = '0; sh = '0; delta = '0; nf = '0; sum = '0; clks = '0;
		nbase = '0; x = 1'b0; f = '0;
		case (op)
			fcsu_pkg::OP_WRITE: begin
				case (idx)
					fcsu_pkg::R_NR11: len_d[0] = 9'd64 - {3'd0, d[5:0]};
					fcsu_pkg::R_NR13: freq_d[0] = {freq_q[0][10:8], d};
					fcsu_pkg::R_NR14: begin
						f = {d[2:0], freq_q[0][7:0]};
						freq_d[0] = f;
						len_en_d[0] = d[6];
						if (d[7]) begin
							von_d[0] = 1'b1;
							if (len_q[0] == 9'd0) len_d[0] = 9'd64;
							timer_d[0] = {(12'd2048 - {1'b0, f}), 1'b0};
							env_act_d[0] = 1'b1;
							env_cnt_d[0] = nr12_q[2:0];
							env_vol_d[0] = nr12_q[7:4];
							sw_shadow_d = f;
							sw_cnt_d = nr10_q[6:4];
							sw_act_d = (nr10_q[6:4] != 3'd0) || (nr10_q[2:0] != 3'd0);
						end
					end
					fcsu_pkg::R_NR21: len_d[1] = 9'd64 - {3'd0, d[5:0]};
					fcsu_pkg::R_NR23: freq_d[1] = {freq_q[1][10:8], d};
					fcsu_pkg::R_NR24: begin
						f = {d[2:0], freq_q[1][7:0]};
						freq_d[1] = f;
						len_en_d[1] = d[6];
						if (d[7]) begin
							von_d[1] = 1'b1;
							if (len_q[1] == 9'd0) len_d[1] = 9'd64;
							timer_d[1] = {(12'd2048 - {1'b0, f}), 1'b0};
							env_act_d[1] = 1'b1;
							env_cnt_d[1] = nr22_q[2:0];
							env_vol_d[1] = nr22_q[7:4];
						end
					end
					fcsu_pkg::R_NR31: len_d[2] = 9'd256 - {1'b0, d};
					fcsu_pkg::R_NR33: freq_d[2] = {freq_q[2][10:8], d};
					fcsu_pkg::R_NR34: begin
						f = {d[2:0], freq_q[2][7:0]};
						freq_d[2] = f;
						len_en_d[2] = d[6];
						if (d[7]) begin
							von_d[2] = 1'b1;
							if (len_q[2] == 9'd0) len_d[2] = 9'd256;
							timer_d[2] = {1'b0, 12'd2048 - {1'b0, f}};
							wstep_d = '0;
						end
					end
					fcsu_pkg::R_NR41: len_d[3] = 9'd64 - {3'd0, d[5:0]};
					fcsu_pkg::R_NR44: begin
						len_en_d[3] = d[6];
						if (d[7]) begin
							von_d[3] = 1'b1;
							if (len_q[3] == 9'd0) len_d[3] = 9'd64;
							env_act_d[2] = 1'b1;
							env_cnt_d[2] = nr42_q[2:0];
							env_vol_d[2] = nr42_q[7:4];
							nshift_d = 15'h7FFF;
						end
					end
					default: ;
				endcase
			end
			fcsu_pkg::OP_TICK: begin
				if (unit_en_q) begin
					phase_d = phase_q + 2'd1;
					for (int v = 0; v < 4; v++) begin
						if (len_en_q[v] && len_q[v] != 9'd0) begin
							len_d[v] = len_q[v] - 9'd1;
							if (len_q[v] == 9'd1) von_d[v] = 1'b0;
						end
					end
					if (phase_d == 2'd3) begin
						for (int e = 0; e < 3; e++) begin
							if (env_act_q[e] && env_ctl[e][2:0] != 3'd0) begin
								env_cnt_d[e] = env_cnt_q[e] - 3'd1;
								if (env_cnt_d[e] == 3'd0) begin
									env_cnt_d[e] = env_ctl[e][2:0];
									if (env_ctl[e][3]) begin
										if (env_vol_q[e] == 4'd15) env_act_d[e] = 1'b0;
										else env_vol_d[e] = env_vol_q[e] + 4'd1;
									end else begin
										if (env_vol_q[e] == 4'd0) env_act_d[e] = 1'b0;
										else env_vol_d[e] = env_vol_q[e] - 4'd1;
									end
								end
							end
						end
					end
					if (phase_d[0]) begin
						per = nr10_q[6:4];
						sh = nr10_q[2:0];
						if (sw_act_q && per != 3'd0) begin
							sw_cnt_d = sw_cnt_q - 3'd1;
							if (sw_cnt_d == 3'd0) begin
								sw_cnt_d = per;
								if (sh != 3'd0) begin
									delta = sw_shadow_q >> sh;
									nf = nr10_q[3] ? ({1'b0, sw_shadow_q} - {1'b0, delta})
										: ({1'b0, sw_shadow_q} + {1'b0, delta});
									if (nf[11] == 1'b0) begin
										sw_shadow_d = nf[10:0];
										freq_d[0] = nf[10:0];
									end else begin
										von_d[0] = 1'b0;
									end
								end
							end
						end
					end
				end
			end
			fcsu_pkg::OP_CYCLE: begin
				if (!nr30_q[7]) von_d[2] = 1'b0;
				for (int v = 0; v < 2; v++) begin
					if (von_q[v]) begin
						timer_d[v] = timer_q[v] - 13'd1;
						if (timer_q[v] == 13'd1) begin
							timer_d[v] = {(12'd2048 - {1'b0, freq_q[v]}), 1'b0};
							duty_d[v] = duty_q[v] + 3'd1;
						end
					end
				end
				if (von_d[2]) begin
					timer_d[2] = timer_q[2] - 13'd1;
					if (timer_q[2] == 13'd1) begin
						timer_d[2] = {1'b0, 12'd2048 - {1'b0, freq_q[2]}};
						wstep_d = wstep_q + 5'd1;
					end
				end
				clks = nr43_q[7:4];
				if (von_q[3] && clks < 4'd14) begin
					ntimer_d = ntimer_q - 20'd1;
					if (ntimer_q == 20'd1) begin
						x = nshift_q[0] ^ nshift_q[1];
						nbase = (nr43_q[2:0] != 3'd0) ? {14'd0, nr43_q[2:0], 3'd0} : 20'd4;
						ntimer_d = nbase << clks;
						nshift_d = {x, nshift_q[14:1]};
						if (nr43_q[3]) nshift_d[6] = x;
					end
				end
				sum = {1'b0, rphase_q} + {1'b0, rate_q};
				if (sum >= fcsu_pkg::CYCLE_RATE) begin
					emit = 1'b1;
					sum = sum - fcsu_pkg::CYCLE_RATE;
					if (sum >= fcsu_pkg::CYCLE_RATE) sum = sum - fcsu_pkg::CYCLE_RATE;
				end
				rphase_d = sum[21:0];
			end
			default: ;
		endcase
	end

	// register read mux
	always_comb begin
		case (idx)
			fcsu_pkg::R_NR10: rdata = nr10_q | 8'h80;
			fcsu_pkg::R_NR11: rdata = nr11_q | 8'h3F;
			fcsu_pkg::R_NR12: rdata = nr12_q;
			fcsu_pkg::R_NR14: rdata = nr14_q | 8'hBF;
			fcsu_pkg::R_NR21: rdata = nr21_q | 8'h3F;
			fcsu_pkg::R_NR22: rdata = nr22_q;
			fcsu_pkg::R_NR24: rdata = nr24_q | 8'hBF;
			fcsu_pkg::R_NR30: rdata = nr30_q | 8'h7F;
			fcsu_pkg::R_NR32: rdata = nr32_q | 8'h9F;
			fcsu_pkg::R_NR34: rdata = nr34_q | 8'hBF;
			fcsu_pkg::R_NR42: rdata = nr42_q;
			fcsu_pkg::R_NR43: rdata = nr43_q;
			fcsu_pkg::R_NR44: rdata = nr44_q | 8'hBF;
			fcsu_pkg::R_NR50: rdata = nr50_q;
			fcsu_pkg::R_NR51: rdata = nr51_q;
			fcsu_pkg::R_NR52: rdata = {unit_en_q, 3'b111, von_q};
			default: rdata = idx[5] && !idx[4] ? wave_q[idx[3:0]] : 8'hFF;
		endcase
	end

	// mix from post-cycle voice state
	fcsu_mixer u_mixer (
		.voice_on   (von_d),
		.nr11       (nr11_q),
		.nr21       (nr21_q),
		.nr32       (nr32_q),
		.nr50       (nr50_q),
		.nr51       (nr51_q),
		.duty_step0 (duty_d[0]),
		.duty_step1 (duty_d[1]),
		.vol0       (env_vol_q[0]),
		.vol1       (env_vol_q[1]),
		.vol3       (env_vol_q[2]),
		.wave_byte  (wave_q[wstep_d[4:1]]),
		.wave_low   (wstep_d[0]),
		.noise_bit  (nshift_d[0]),
		.level1     (lvl1),
		.level2     (lvl2)
	);

	always_comb begin
		res = '0;
		if (op == fcsu_pkg::OP_READ) res.read_data = rdata;
		if (op == fcsu_pkg::OP_CYCLE && emit) begin
			res.sample_valid = 1'b1;
			if (unit_en_q) begin
				res.terminal1_level = lvl1;
				res.terminal2_level = lvl2;
			end
		end
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= fcsu_pkg::RATE_RESET;
			nr10_q <= '0; nr11_q <= '0; nr12_q <= '0; nr14_q <= '0;
			nr21_q <= '0; nr22_q <= '0; nr24_q <= '0; nr30_q <= '0;
			nr32_q <= '0; nr34_q <= '0; nr42_q <= '0; nr43_q <= '0;
			nr44_q <= '0; nr50_q <= '0; nr51_q <= '0;
			unit_en_q <= 1'b0; phase_q <= '0; von_q <= '0; len_en_q <= '0;
			len_q <= '{default: '0}; env_act_q <= '0;
			env_vol_q <= '{default: '0}; env_cnt_q <= '{default: '0};
			freq_q <= '{default: '0}; timer_q <= '{default: '0};
			duty_q <= '{default: '0}; wstep_q <= '0; sw_act_q <= 1'b0;
			sw_shadow_q <= '0; sw_cnt_q <= '0; ntimer_q <= '0; nshift_q <= '0;
			wave_q <= '{default: '0}; rphase_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) rate_q <= cfg_wdata;
			if (accept) begin
				von_q <= von_d; len_en_q <= len_en_d; len_q <= len_d;
				env_act_q <= env_act_d; env_vol_q <= env_vol_d; env_cnt_q <= env_cnt_d;
				freq_q <= freq_d; timer_q <= timer_d; duty_q <= duty_d;
				wstep_q <= wstep_d; sw_act_q <= sw_act_d; sw_shadow_q <= sw_shadow_d;
				sw_cnt_q <= sw_cnt_d; ntimer_q <= ntimer_d; nshift_q <= nshift_d;
				phase_q <= phase_d; rphase_q <= rphase_d;
				if (op == fcsu_pkg::OP_WRITE) begin
					case (idx)
						fcsu_pkg::R_NR10: nr10_q <= d;
						fcsu_pkg::R_NR11: nr11_q <= d;
						fcsu_pkg::R_NR12: nr12_q <= d;
						fcsu_pkg::R_NR14: nr14_q <= d;
						fcsu_pkg::R_NR21: nr21_q <= d;
						fcsu_pkg::R_NR22: nr22_q <= d;
						fcsu_pkg::R_NR24: nr24_q <= d;
						fcsu_pkg::R_NR30: nr30_q <= d;
						fcsu_pkg::R_NR32: nr32_q <= d;
						fcsu_pkg::R_NR34: nr34_q <= d;
						fcsu_pkg::R_NR42: nr42_q <= d;
						fcsu_pkg::R_NR43: nr43_q <= d;
						fcsu_pkg::R_NR44: nr44_q <= d;
						fcsu_pkg::R_NR50: nr50_q <= d;
						fcsu_pkg::R_NR51: nr51_q <= d;
						fcsu_pkg::R_NR52: unit_en_q <= d[7];
						default: if (idx[5] && !idx[4]) wave_q[idx[3:0]] <= d;
					endcase
				end
			end
			if (accept) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (accept) out_item <= res;
	end
endmodule

// File: tb/four_channel_sound_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_channel_sound_unit_checker: behavioral predictor and result checker
// Watches the input and output transfers, runs a cycle-level model of the
// four voices, the frame ticks and the sample-rate accumulator, and compares
// every result with the oldest prediction.
// ----------------------------------------------------------------------------
module four_channel_sound_unit_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  fcsu_pkg::in_item_t   in_item,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  fcsu_pkg::out_item_t  out_item,
	input  logic                 cfg_we,
	input  logic [21:0]          cfg_wdata,
	output int                   fail_count,
	output int                   pending
);

	// shadow of the sound unit
	logic [21:0] rate;
	logic [7:0]  nr10, nr11, nr12, nr14, nr21, nr22, nr24, nr30, nr32, nr34;
	logic [7:0]  nr42, nr43, nr44, nr50, nr51;
	logic        power;
	logic [1:0]  phase;
	logic [3:0]  on, len_en;
	logic [8:0]  len_cnt [4];
	logic [2:0]  env_on;
	logic [3:0]  env_vol [3];
	logic [2:0]  env_cnt [3];
	logic [10:0] freq [3];
	logic [12:0] timer [3];
	logic [2:0]  duty_pos [2];
	logic [4:0]  wave_pos;
	logic        sw_on;
	logic [10:0] sw_shadow;
	logic [2:0]  sw_cnt;
	logic [19:0] nz_timer;
	logic [14:0] lfsr;
	logic [7:0]  wave_ram [16];
	logic [21:0] acc;

	fcsu_pkg::out_item_t sound_results [$];

	function automatic logic [7:0] duty_bits(input logic [1:0] s);
		case (s)
			2'd0: return 8'b00000001;
			2'd1: return 8'b10000001;
			2'd2: return 8'b10000111;
			default: return 8'b01111110;
		endcase
	endfunction

	task automatic env_step(input int e, input logic [7:0] ctl);
		if (env_on[e] && ctl[2:0] != 0) begin
			env_cnt[e] = env_cnt[e] - 3'd1;
			if (env_cnt[e] == 0) begin
				env_cnt[e] = ctl[2:0];
				if (ctl[3]) begin
					if (env_vol[e] == 15) env_on[e] = 1'b0;
					else env_vol[e]++;
				end else begin
					if (env_vol[e] == 0) env_on[e] = 1'b0;
					else env_vol[e]--;
				end
			end
		end
	endtask

	task automatic frame_step();
		logic [11:0] delta, nf;
		if (power) begin
			phase = phase + 2'd1;
			for (int v = 0; v < 4; v++)
				if (len_en[v] && len_cnt[v] != 0) begin
					len_cnt[v]--;
					if (len_cnt[v] == 0) on[v] = 1'b0;
				end
			if (phase == 3) begin
				env_step(0, nr12);
				env_step(1, nr22);
				env_step(2, nr42);
			end
			if (phase[0] && sw_on && nr10[6:4] != 0) begin
				sw_cnt = sw_cnt - 3'd1;
				if (sw_cnt == 0) begin
					sw_cnt = nr10[6:4];
					if (nr10[2:0] != 0) begin
						delta = {1'b0, sw_shadow >> nr10[2:0]};
						nf = nr10[3] ? {1'b0, sw_shadow} - delta : {1'b0, sw_shadow} + delta;
						if (nf < 12'd2048) begin
							sw_shadow = nf[10:0];
							freq[0] = nf[10:0];
						end else on[0] = 1'b0;
					end
				end
			end
		end
	endtask

	task automatic cycle_step();
		logic [3:0] ck;
		logic       x;
		ck = nr43[7:4];
		if (!nr30[7]) on[2] = 1'b0;
		for (int v = 0; v < 2; v++)
			if (on[v]) begin
				timer[v] = timer[v] - 13'd1;
				if (timer[v] == 0) begin
					timer[v] = 13'd2 * (13'd2048 - {2'd0, freq[v]});
					duty_pos[v] = duty_pos[v] + 3'd1;
				end
			end
		if (on[2]) begin
			timer[2] = timer[2] - 13'd1;
			if (timer[2] == 0) begin
				timer[2] = 13'd2048 - {2'd0, freq[2]};
				wave_pos = wave_pos + 5'd1;
			end
		end
		if (on[3] && ck < 14) begin
			nz_timer = nz_timer - 20'd1;
			if (nz_timer == 0) begin
				x = lfsr[0] ^ lfsr[1];
				nz_timer = ((nr43[2:0] != 0) ? 20'(nr43[2:0]) * 20'd8 : 20'd4) << ck;
				lfsr = {x, lfsr[14:1]};
				if (nr43[3]) lfsr[6] = x;
			end
		end
	endtask

	task automatic mix_levels(output logic [8:0] t1, output logic [8:0] t2);
		logic [3:0] lv [4];
		logic [7:0] b;
		logic [3:0] n;
		logic [7:0] pat0, pat1;
		int s1, s2;
		s1 = 0;
		s2 = 0;
		pat0 = duty_bits(nr11[7:6]);
		pat1 = duty_bits(nr21[7:6]);
		lv[0] = (on[0] && pat0[duty_pos[0]]) ? env_vol[0] : 4'd0;
		lv[1] = (on[1] && pat1[duty_pos[1]]) ? env_vol[1] : 4'd0;
		lv[2] = 4'd0;
		if (on[2] && nr32[6:5] != 0) begin
			b = wave_ram[wave_pos[4:1]];
			n = wave_pos[0] ? b[3:0] : b[7:4];
			lv[2] = n >> (nr32[6:5] - 2'd1);
		end
		lv[3] = (on[3] && !lfsr[0]) ? env_vol[2] : 4'd0;
		for (int v = 0; v < 4; v++) begin
			if (nr51[v]) s1 += lv[v];
			if (nr51[v + 4]) s2 += lv[v];
		end
		t1 = 9'(s1 * (nr50[2:0] + 1));
		t2 = 9'(s2 * (nr50[6:4] + 1));
	endtask

	task automatic set_high(input int v, input logic [7:0] d, output logic trig);
		freq[v] = {d[2:0], freq[v][7:0]};
		len_en[v] = d[6];
		trig = d[7];
		if (d[7]) begin
			on[v] = 1'b1;
			if (len_cnt[v] == 0) len_cnt[v] = (v == 2) ? 9'd256 : 9'd64;
		end
	endtask

	task automatic env_start(input int e, input logic [7:0] ctl);
		env_on[e] = 1'b1;
		env_cnt[e] = ctl[2:0];
		env_vol[e] = ctl[7:4];
	endtask

	task automatic register_write(input logic [5:0] a, input logic [7:0] d);
		logic t;
		case (a)
			fcsu_pkg::R_NR10: nr10 = d;
			fcsu_pkg::R_NR11: begin nr11 = d; len_cnt[0] = 9'd64 - {3'd0, d[5:0]}; end
			fcsu_pkg::R_NR12: nr12 = d;
			fcsu_pkg::R_NR13: freq[0][7:0] = d;
			fcsu_pkg::R_NR14: begin
				nr14 = d;
				set_high(0, d, t);
				if (t) begin
					timer[0] = 13'd2 * (13'd2048 - {2'd0, freq[0]});
					env_start(0, nr12);
					sw_shadow = freq[0];
					sw_cnt = nr10[6:4];
					sw_on = (nr10[6:4] != 0) || (nr10[2:0] != 0);
				end
			end
			fcsu_pkg::R_NR21: begin nr21 = d; len_cnt[1] = 9'd64 - {3'd0, d[5:0]}; end
			fcsu_pkg::R_NR22: nr22 = d;
			fcsu_pkg::R_NR23: freq[1][7:0] = d;
			fcsu_pkg::R_NR24: begin
				nr24 = d;
				set_high(1, d, t);
				if (t) begin
					timer[1] = 13'd2 * (13'd2048 - {2'd0, freq[1]});
					env_start(1, nr22);
				end
			end
			fcsu_pkg::R_NR30: nr30 = d;
			fcsu_pkg::R_NR31: len_cnt[2] = 9'd256 - {1'b0, d};
			fcsu_pkg::R_NR32: nr32 = d;
			fcsu_pkg::R_NR33: freq[2][7:0] = d;
			fcsu_pkg::R_NR34: begin
				nr34 = d;
				set_high(2, d, t);
				if (t) begin
					timer[2] = 13'd2048 - {2'd0, freq[2]};
					wave_pos = 5'd0;
				end
			end
			fcsu_pkg::R_NR41: len_cnt[3] = 9'd64 - {3'd0, d[5:0]};
			fcsu_pkg::R_NR42: nr42 = d;
			fcsu_pkg::R_NR43: nr43 = d;
			fcsu_pkg::R_NR44: begin
				nr44 = d;
				len_en[3] = d[6];
				if (d[7]) begin
					on[3] = 1'b1;
					if (len_cnt[3] == 0) len_cnt[3] = 9'd64;
					env_start(2, nr42);
					lfsr = 15'h7FFF;
				end
			end
			fcsu_pkg::R_NR50: nr50 = d;
			fcsu_pkg::R_NR51: nr51 = d;
			fcsu_pkg::R_NR52: power = d[7];
			default: if (a >= 32 && a < 48) wave_ram[a[3:0]] = d;
		endcase
	endtask

	function automatic logic [7:0] register_read(input logic [5:0] a);
		case (a)
			fcsu_pkg::R_NR10: return nr10 | 8'h80;
			fcsu_pkg::R_NR11: return nr11 | 8'h3F;
			fcsu_pkg::R_NR12: return nr12;
			fcsu_pkg::R_NR14: return nr14 | 8'hBF;
			fcsu_pkg::R_NR21: return nr21 | 8'h3F;
			fcsu_pkg::R_NR22: return nr22;
			fcsu_pkg::R_NR24: return nr24 | 8'hBF;
			fcsu_pkg::R_NR30: return nr30 | 8'h7F;
			fcsu_pkg::R_NR32: return nr32 | 8'h9F;
			fcsu_pkg::R_NR34: return nr34 | 8'hBF;
			fcsu_pkg::R_NR42: return nr42;
			fcsu_pkg::R_NR43: return nr43;
			fcsu_pkg::R_NR44: return nr44 | 8'hBF;
			fcsu_pkg::R_NR50: return nr50;
			fcsu_pkg::R_NR51: return nr51;
			fcsu_pkg::R_NR52: return {power, 3'b111, on[3], on[2], on[1], on[0]};
			default: return (a >= 32 && a < 48) ? wave_ram[a[3:0]] : 8'hFF;
		endcase
	endfunction

	task automatic predict_item(input fcsu_pkg::in_item_t it);
		fcsu_pkg::out_item_t r;
		logic [22:0] sum;
		r = '0;
		case (it.op)
			fcsu_pkg::OP_WRITE: register_write(it.reg_index, it.write_data);
			fcsu_pkg::OP_READ:  r.read_data = register_read(it.reg_index);
			fcsu_pkg::OP_TICK:  frame_step();
			default: begin
				cycle_step();
				sum = {1'b0, acc} + {1'b0, rate};
				if (sum >= fcsu_pkg::CYCLE_RATE) begin
					r.sample_valid = 1'b1;
					if (power) mix_levels(r.terminal1_level, r.terminal2_level);
				end
				acc = 22'(sum % fcsu_pkg::CYCLE_RATE);
			end
		endcase
		sound_results = {sound_results, r};
	endtask

	// reset, config writes, transfers on both channels
	always @(posedge clk or negedge arst_n) begin
		fcsu_pkg::out_item_t want;
		if (!arst_n) begin
			rate = 22'd44100;
			{nr10, nr11, nr12, nr14, nr21, nr22, nr24, nr30} = '0;
			{nr32, nr34, nr42, nr43, nr44, nr50, nr51} = '0;
			power = 0; phase = 0; on = 0; len_en = 0; env_on = 0;
			for (int i = 0; i < 4; i++) len_cnt[i] = 0;
			for (int i = 0; i < 3; i++) begin
				env_vol[i] = 0; env_cnt[i] = 0; freq[i] = 0; timer[i] = 0;
			end
			duty_pos[0] = 0; duty_pos[1] = 0; wave_pos = 0;
			sw_on = 0; sw_shadow = 0; sw_cnt = 0; nz_timer = 0; lfsr = 0;
			for (int i = 0; i < 16; i++) wave_ram[i] = 0;
			acc = 0;
			fail_count = 0;
			sound_results.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (sound_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result transfer: %p", out_item);
				end else begin
					want = sound_results.pop_front();
					if (out_item.read_data !== want.read_data
							|| out_item.sample_valid !== want.sample_valid
							|| out_item.terminal1_level !== want.terminal1_level
							|| out_item.terminal2_level !== want.terminal2_level) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %p, got %p", want, out_item);
					end
				end
			end
			if (cfg_we) rate = cfg_wdata;
			if (in_valid && !in_stall) predict_item(in_item);
			pending = sound_results.size();
		end
	end

endmodule

// File: tb/four_channel_sound_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_channel_sound_unit_tb: stimulus and verdict for the sound unit
// Directed register and voice checks, then random phases of register
// traffic, frame ticks and cycles under several sample rates, with random
// gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module four_channel_sound_unit_tb;

	logic                 clk, arst_n;
	logic                 in_valid, in_stall, out_valid, out_stall, cfg_we;
	fcsu_pkg::in_item_t   in_item;
	fcsu_pkg::out_item_t  out_item;
	logic [21:0]          cfg_wdata;
	int                   fail_count, pending, cycles;
	int                   stall_left;
	bit                   long_stall;

	four_channel_sound_unit uut (.*);
	four_channel_sound_unit_checker chk (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// timeout
	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) return 0;
		if (k < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// output stall runs of random length, occasionally quiet for a stretch
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0) long_stall = ~long_stall;
		if (stall_left == 0 && !long_stall && $urandom_range(0, 3) == 0)
			stall_left = gap_len();
		out_stall <= (stall_left != 0);
		if (stall_left != 0) stall_left--;
	end

	task automatic send(input logic [1:0] op, input logic [5:0] a, input logic [7:0] d);
		int g;
		g = long_stall ? 0 : gap_len();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_item <= '{op: op, reg_index: a, write_data: d};
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic cycles_run(input int n);
		repeat (n) send(fcsu_pkg::OP_CYCLE, 6'd0, 8'd0);
	endtask

	task automatic drain_and_set_rate(input logic [21:0] r);
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_wdata <= r;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// a well-formed voice setup followed by cycles, ticks, reads and random writes
	task automatic random_voice();
		logic [5:0] base;
		int v;
		v = $urandom_range(0, 3);
		send(fcsu_pkg::OP_WRITE, fcsu_pkg::R_NR52, 8'h80);
		send(fcsu_pkg::OP_WRITE, fcsu_pkg::R_NR50, 8'($urandom));
		send(fcsu_pkg::OP_WRITE, fcsu_pkg::R_NR51, 8'($urandom));
		case (v)
			0: base = fcsu_pkg::R_NR10;
			1: base = fcsu_pkg::R_NR21 - 6'd1;
			2: base = fcsu_pkg::R_NR30;
			default: base = fcsu_pkg::R_NR41 - 6'd1;
		endcase
		if (v == 0) send(fcsu_pkg::OP_WRITE, fcsu_pkg::R_NR10, 8'($urandom));
		if (v == 2) send(fcsu_pkg::OP_WRITE, fcsu_pkg::R_NR30, {1'b1, 7'($urandom)});
		send(fcsu_pkg::OP_WRITE, base + 6'd1, 8'($urandom));
		send(fcsu_pkg::OP_WRITE, base + 6'd2, {4'($urandom), 4'($urandom_range(0, 3))});
		if (v == 3)
			send(fcsu_pkg::OP_WRITE, fcsu_pkg::R_NR43,
				{4'($urandom_range(0, 15)), 4'($urandom)});
		else send(fcsu_pkg::OP_WRITE, base + 6'd3, 8'($urandom_range(200, 255)));
		send(fcsu_pkg::OP_WRITE, base + 6'd4, {1'b1, 4'($urandom), 3'b111});
		repeat ($urandom_range(3, 12)) begin
			case ($urandom_range(0, 9))
				0, 1: send(fcsu_pkg::OP_TICK, 6'd0, 8'($urandom));
				2: send(fcsu_pkg::OP_READ, 6'($urandom_range(0, 47)), 8'($urandom));
				3: send(fcsu_pkg::OP_WRITE, 6'($urandom), 8'($urandom));
				default: cycles_run($urandom_range(1, 12));
			endcase
		end
	endtask

	logic [21:0] rates [6] = '{22'd0, 22'd1000, 22'd44100, 22'd2097152, 22'h3FFFFF, 22'd524288};

	initial begin
		arst_n = 0; in_valid = 0; in_item = '0; out_stall = 0;
		cfg_we = 0; cfg_wdata = '0; long_stall = 0; cycles = 0;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed: status read at reset, wave memory extremes, unmapped offsets
		send(fcsu_pkg::OP_READ, fcsu_pkg::R_NR52, 8'h00);
		send(fcsu_pkg::OP_WRITE, 6'd32, 8'hFF);
		send(fcsu_pkg::OP_WRITE, 6'd47, 8'h00);
		send(fcsu_pkg::OP_WRITE, 6'd5, 8'hAA);
		send(fcsu_pkg::OP_READ, 6'd47, 8'h00);
		send(fcsu_pkg::OP_READ, 6'd63, 8'h00);
		send(fcsu_pkg::OP_TICK, 6'd0, 8'h00); // unit off, tick ignored
		send(fcsu_pkg::OP_WRITE, fcsu_pkg::R_NR52, 8'h80);
		send(fcsu_pkg::OP_WRITE, fcsu_pkg::R_NR50, 8'h77);
		send(fcsu_pkg::OP_WRITE, fcsu_pkg::R_NR51, 8'hFF);
		send(fcsu_pkg::OP_WRITE, fcsu_pkg::R_NR12, 8'hF1);
		send(fcsu_pkg::OP_WRITE, fcsu_pkg::R_NR11, 8'hC0);
		send(fcsu_pkg::OP_WRITE, fcsu_pkg::R_NR13, 8'hFF);
		send(fcsu_pkg::OP_WRITE, fcsu_pkg::R_NR14, 8'hC7);
		send(fcsu_pkg::OP_WRITE, fcsu_pkg::R_NR42, 8'hF0);
		send(fcsu_pkg::OP_WRITE, fcsu_pkg::R_NR43, 8'hF0); // noise clock too slow to run
		send(fcsu_pkg::OP_WRITE, fcsu_pkg::R_NR44, 8'h80);
		send(fcsu_pkg::OP_WRITE, fcsu_pkg::R_NR10, 8'h7F); // sweep down, max period
		cycles_run(3);
		send(fcsu_pkg::OP_TICK, 6'd0, 8'h00);
		send(fcsu_pkg::OP_READ, fcsu_pkg::R_NR52, 8'h00);
		drain_and_set_rate(22'd2097152);
		cycles_run(30);
		// random phases with different sample rates
		for (int p = 0; p < 6; p++) begin
			drain_and_set_rate(rates[$urandom_range(0, 5)]);
			if (p == 5) drain_and_set_rate(22'h3FFFFF);
			repeat (4) begin
				if ($urandom_range(0, 4) == 0)
					send(2'($urandom), 6'($urandom), 8'($urandom));
				else random_voice();
			end
		end
		drain_and_set_rate(22'd1000);
		cycles_run(10);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: filelist.f
rtl/fcsu_pkg.sv
rtl/fcsu_mixer.sv
rtl/four_channel_sound_unit.sv
tb/four_channel_sound_unit_checker.sv
tb/four_channel_sound_unit_tb.sv
